// ----- hdl/box_filter_downscaler_gray8_macros.svh -----
// Assertion macros for the box filter downscaler checker.
`ifndef BOX_FILTER_DOWNSCALER_GRAY8_MACROS_SVH
`define BOX_FILTER_DOWNSCALER_GRAY8_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define BFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define BFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/bfd_pkg.sv -----
package bfd_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_SRC_DIM   = 4096;
    localparam int MAX_DST_WIDTH = 64;
    localparam int SUM_W         = 32;
    localparam int CNT_W         = 25;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_SCALE_X    = 3'd4;
    localparam logic [2:0] CFG_SCALE_Y    = 3'd5;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_RD,
        ST_LD,
        ST_DIV,
        ST_OUT,
        ST_CLR
    } t_state;

endpackage

// ----- hdl/bfd_mem.sv -----
module bfd_mem #(
    parameter int DEPTH = bfd_pkg::MAX_DST_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  bfd_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output bfd_pkg::t_entry  o_rdata
);

    bfd_pkg::t_entry r_mem [DEPTH];
    bfd_pkg::t_entry r_rd;
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

// ----- hdl/bfd_div.sv -----
module bfd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bfd_pkg::SUM_W-1:0] i_sum,
    input  logic [bfd_pkg::CNT_W-1:0] i_cnt,
    output logic                      o_done,
    output logic [7:0]                o_quot
);

    // quotient of an average never exceeds 255, so eight restoring steps suffice
    logic                      r_busy;
    logic                      r_done;
    logic [2:0]                r_k;
    logic [bfd_pkg::SUM_W-1:0] r_rem;
    logic [bfd_pkg::CNT_W-1:0] r_den;
    logic [7:0]                r_quot;
    logic [bfd_pkg::SUM_W:0]   w_trial;
    logic                      w_fit;

    always_comb begin
        w_trial = {{(bfd_pkg::SUM_W + 1 - bfd_pkg::CNT_W){1'b0}}, r_den} << r_k;
        w_fit   = {1'b0, r_rem} >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= 3'd7;
            r_rem  <= i_sum;
            r_den  <= i_cnt;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - w_trial[bfd_pkg::SUM_W-1:0];
            end
            r_quot[r_k] <= w_fit;
            r_k         <= r_k - 3'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/box_filter_downscaler_gray8.sv -----
// Box filter downscaler, 8-bit grey.
// Input channel: i_valid / o_stall carry one source pixel in raster order.
// Output channel: o_valid / i_stall carry one averaged output pixel with
// row_end, image_end and empty_box flags; one transfer per output column.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 src_width, 1 src_height, 2 dst_width, 3 dst_height, 4 scale_x,
// 5 scale_y); write only while the block is idle.
// A pixel that closes no output row is read, then written back to the column
// accumulator in the sum/count memory.
// A pixel that closes an output row then drains dst_width columns; each is
// read, its entry cleared, divided in the restoring divider (skipped for an
// empty column) and put in the output register, held there by any receiver
// stall; then the unused entries beyond dst_width are cleared.
// o_stall is high while a pixel or a row drain is in progress, so only one
// item is in flight; a stalled output simply holds the drain.
// Reset clears all counters and marks every accumulator entry as zero at once;
// the registers return to 1x1 source, 1x1 output, unity scales.
// After the last output row, further pixels are accepted and dropped.
module box_filter_downscaler_gray8 #(
    parameter int MAX_DST_WIDTH = bfd_pkg::MAX_DST_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_out,
    output logic        o_row_end,
    output logic        o_image_end,
    output logic        o_empty_box,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    localparam int AW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int FB = bfd_pkg::FRAC_BITS;
    localparam logic [AW-1:0] LAST_COL = AW'(MAX_DST_WIDTH - 1);

    // configuration
    logic [12:0] r_src_width, r_src_height, r_dst_height;
    logic [6:0]  r_dst_width;
    logic [16:0] r_scale_x, r_scale_y;

    // control state
    bfd_pkg::t_state r_state, n_state;
    logic [11:0] r_src_col;
    logic [12:0] r_src_row;
    logic [12:0] r_out_row;
    logic        r_frame_done;
    logic        r_last;
    logic [AW-1:0] r_col;
    logic [AW-1:0] r_dx;
    logic [7:0]  r_pix;

    // output register
    logic        r_o_valid;
    logic [7:0]  r_o_pix;
    logic        r_o_row_end, r_o_img_end, r_o_empty;

    // memory and divider
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    bfd_pkg::t_entry w_wdata, w_rdata;
    logic            w_div_start, w_div_done;
    logic [7:0]      w_quot;

    logic [12:0] w_sw, w_sh;
    logic [6:0]  w_dw, w_dw_m1;
    logic [16:0] w_sy;
    logic        w_active, w_accept;
    logic [28:0] w_prod;
    logic [12:0] w_dx_full;
    logic [AW-1:0] w_dx;
    logic [12:0] w_col_n;
    logic [13:0] w_row_n;
    logic [31:0] w_row_scaled, w_row_bound;
    logic        w_row_done, w_emit, w_last, w_last_col;

    always_comb begin
        w_sw = (r_src_width == 13'd0) ? 13'd1 :
               (r_src_width > 13'(bfd_pkg::MAX_SRC_DIM)) ? 13'(bfd_pkg::MAX_SRC_DIM) :
               r_src_width;
        w_sh = (r_src_height == 13'd0) ? 13'd1 :
               (r_src_height > 13'(bfd_pkg::MAX_SRC_DIM)) ? 13'(bfd_pkg::MAX_SRC_DIM) :
               r_src_height;
        w_dw = (r_dst_width == 7'd0) ? 7'd1 :
               (r_dst_width > 7'(MAX_DST_WIDTH)) ? 7'(MAX_DST_WIDTH) : r_dst_width;
        w_dw_m1 = w_dw - 7'd1;
        w_sy = (r_scale_y > 17'(1 << FB)) ? 17'(1 << FB) : r_scale_y;

        w_active = !r_frame_done && (r_out_row < r_dst_height) && (r_src_row < w_sh);
        w_accept = i_valid && !o_stall;

        w_prod    = r_scale_x * {5'd0, r_src_col};
        w_dx_full = 13'(w_prod >> FB);
        w_dx      = (w_dx_full > {6'd0, w_dw_m1}) ? AW'(w_dw_m1) : AW'(w_dx_full);

        w_col_n      = {1'b0, r_src_col} + 13'd1;
        w_row_n      = {1'b0, r_src_row} + 14'd1;
        w_row_done   = w_col_n >= w_sw;
        w_row_scaled = {18'd0, w_row_n} * {15'd0, w_sy};
        w_row_bound  = 32'({1'b0, r_out_row} + 14'd1) << FB;
        w_emit = w_row_done &&
                 !((w_row_n < {1'b0, w_sh}) && (w_row_scaled < w_row_bound));
        w_last = (({1'b0, r_out_row} + 14'd1) >= {1'b0, r_dst_height}) ||
                 (w_row_n >= {1'b0, w_sh});
        w_last_col = {{(7 - AW){1'b0}}, r_col} == w_dw_m1;
    end

    // next state and memory / divider control
    always_comb begin
        n_state     = r_state;
        w_we        = 1'b0;
        w_waddr     = r_dx;
        w_wdata     = '0;
        w_raddr     = r_col;
        w_div_start = 1'b0;
        case (r_state)
            bfd_pkg::ST_IDLE: begin
                w_raddr = w_dx;
                if (w_accept && w_active) begin
                    n_state = bfd_pkg::ST_ACC;
                end
            end
            bfd_pkg::ST_ACC: begin
                w_we        = 1'b1;
                w_wdata.sum = w_rdata.sum + {24'd0, r_pix};
                w_wdata.cnt = w_rdata.cnt + 25'd1;
                n_state     = w_emit ? bfd_pkg::ST_RD : bfd_pkg::ST_IDLE;
            end
            bfd_pkg::ST_RD: begin
                n_state = bfd_pkg::ST_LD;
            end
            bfd_pkg::ST_LD: begin
                // clear the column as it is drained
                w_we    = 1'b1;
                w_waddr = r_col;
                if (w_rdata.cnt == '0) begin
                    n_state = bfd_pkg::ST_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = bfd_pkg::ST_DIV;
                end
            end
            bfd_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = bfd_pkg::ST_OUT;
                end
            end
            bfd_pkg::ST_OUT: begin
                if (!i_stall) begin
                    if (!w_last_col) begin
                        n_state = bfd_pkg::ST_RD;
                    end else if (r_col == LAST_COL) begin
                        n_state = bfd_pkg::ST_IDLE;
                    end else begin
                        n_state = bfd_pkg::ST_CLR;
                    end
                end
            end
            bfd_pkg::ST_CLR: begin
                // zero the columns beyond the current output width
                w_we    = 1'b1;
                w_waddr = r_col;
                if (r_col == LAST_COL) begin
                    n_state = bfd_pkg::ST_IDLE;
                end
            end
            default: n_state = bfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 13'd1;
            r_src_height <= 13'd1;
            r_dst_width  <= 7'd1;
            r_dst_height <= 13'd1;
            r_scale_x    <= 17'(1 << FB);
            r_scale_y    <= 17'(1 << FB);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfd_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[12:0];
                bfd_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[12:0];
                bfd_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[6:0];
                bfd_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[12:0];
                bfd_pkg::CFG_SCALE_X:    r_scale_x    <= i_cfg_data;
                bfd_pkg::CFG_SCALE_Y:    r_scale_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_out_row    <= '0;
            r_frame_done <= 1'b0;
            r_last       <= 1'b0;
            r_col        <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            case (r_state)
                bfd_pkg::ST_ACC: begin
                    if (w_row_done) begin
                        r_src_col <= '0;
                        r_src_row <= w_row_n[12:0];
                    end else begin
                        r_src_col <= w_col_n[11:0];
                    end
                    r_last <= w_last;
                    r_col  <= '0;
                end
                bfd_pkg::ST_LD: begin
                    if (w_rdata.cnt == '0) begin
                        r_o_valid <= 1'b1;
                    end
                end
                bfd_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        r_o_valid <= 1'b1;
                    end
                end
                bfd_pkg::ST_OUT: begin
                    if (!i_stall) begin
                        r_o_valid <= 1'b0;
                        r_col     <= r_col + AW'(1);
                        if (w_last_col) begin
                            r_out_row    <= r_out_row + 13'd1;
                            r_frame_done <= r_frame_done | r_last;
                        end
                    end
                end
                bfd_pkg::ST_CLR: begin
                    r_col <= r_col + AW'(1);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == bfd_pkg::ST_IDLE && w_accept) begin
            r_pix <= i_pixel_in;
            r_dx  <= w_dx;
        end
        if (r_state == bfd_pkg::ST_LD) begin
            r_o_pix     <= '0;
            r_o_empty   <= (w_rdata.cnt == '0);
            r_o_row_end <= w_last_col;
            r_o_img_end <= w_last_col && r_last;
        end else if (r_state == bfd_pkg::ST_DIV && w_div_done) begin
            r_o_pix <= w_quot;
        end
    end

    bfd_mem #(
        .DEPTH (MAX_DST_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bfd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_rdata.sum),
        .i_cnt   (w_rdata.cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall     = (r_state != bfd_pkg::ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_pixel_out = r_o_pix;
    assign o_row_end   = r_o_row_end;
    assign o_image_end = r_o_img_end;
    assign o_empty_box = r_o_empty;

endmodule

// ----- hdl/bfd_chk.sv -----
`include "box_filter_downscaler_gray8_macros.svh"

module bfd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_pixel_out,
    input logic       o_row_end,
    input logic       o_image_end,
    input logic       o_empty_box
);

    `BFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pixel_out))
    `BFD_ASSERT_IMPL(a_img_end_row, i_clk, i_rst_n, o_valid && o_image_end, o_row_end)
    `BFD_ASSERT_IMPL(a_empty_zero, i_clk, i_rst_n, o_valid && o_empty_box, o_pixel_out == 8'd0)
    `BFD_ASSERT_IMPL(a_busy_drain, i_clk, i_rst_n, o_valid, o_stall)

endmodule

bind box_filter_downscaler_gray8 bfd_chk u_bfd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_pixel_out (o_pixel_out),
    .o_row_end   (o_row_end),
    .o_image_end (o_image_end),
    .o_empty_box (o_empty_box)
);
